[hdl/ftc_pkg.sv]
`timescale 1ns / 1ps

package ftc_pkg;

  localparam int VALUE_W = 12;
  localparam int FREQ_W  = 12;

  typedef logic [1:0]         command_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [FREQ_W-1:0]  freq_t;
  typedef logic [1:0]         status_t;

  localparam command_t CMD_ADD    = 2'd0;
  localparam command_t CMD_DELETE = 2'd1;
  localparam command_t CMD_QUERY  = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_ABSENT    = 2'd1;
  localparam status_t ST_SATURATED = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDCNT,
    S_WRFROM,
    S_WRTO,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clr;
    logic capture;
    logic eval;
    logic upd;
    logic wr_from;
    logic wr_to;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic modify;
    logic out_free;
  } dp_sts_t;

endpackage

[hdl/ftc_in_if.sv]
`timescale 1ns / 1ps

interface ftc_in_if;
  logic              valid;
  logic              ready;
  ftc_pkg::command_t command;
  ftc_pkg::value_t   value;
  ftc_pkg::freq_t    frequency;

  modport source (output valid, output command, output value, output frequency, input ready);
  modport sink   (input valid, input command, input value, input frequency, output ready);
endinterface

[hdl/ftc_out_if.sv]
`timescale 1ns / 1ps

interface ftc_out_if;
  logic             valid;
  logic             ready;
  logic             found;
  ftc_pkg::status_t status;

  modport source (output valid, output found, output status, input ready);
  modport sink   (input valid, input found, input status, output ready);
endinterface

[hdl/ftc_ctrl.sv]
`timescale 1ns / 1ps

module ftc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ftc_pkg::dp_sts_t   sts,
  output ftc_pkg::ctrl_cmd_t cmd
);
  import ftc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_RDCNT;
      end
      S_RDCNT: begin
        state_nxt = sts.modify ? S_WRFROM : S_RESP;
      end
      S_WRFROM: begin
        state_nxt = S_WRTO;
      end
      S_WRTO: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_RDCNT: begin
        cmd.eval = 1'b1;
        cmd.upd  = sts.modify;
      end
      S_WRFROM: begin
        cmd.wr_from = 1'b1;
      end
      S_WRTO: begin
        cmd.wr_to = 1'b1;
      end
      S_RESP: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hdl/ftc_dp.sv]
`timescale 1ns / 1ps

module ftc_dp #(
  parameter int NUM_VALUES = 4096,
  parameter int MAX_COUNT  = 4095
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ftc_pkg::ctrl_cmd_t cmd,
  output ftc_pkg::dp_sts_t   sts,
  input  ftc_pkg::command_t  in_command,
  input  ftc_pkg::value_t    in_value,
  input  ftc_pkg::freq_t     in_frequency,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output ftc_pkg::status_t   out_status
);
  import ftc_pkg::*;

  localparam int VW        = $clog2(NUM_VALUES);
  localparam int CW        = $clog2(MAX_COUNT + 1);
  localparam int PW        = $clog2(NUM_VALUES + 1);
  localparam int POP_DEPTH = MAX_COUNT + 1;
  localparam int CLR_DEPTH = (NUM_VALUES > POP_DEPTH) ? NUM_VALUES : POP_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  logic [CW-1:0] vc_mem  [NUM_VALUES];
  logic [PW-1:0] pop_mem [POP_DEPTH];

  logic [CLR_W-1:0] clr_r;
  command_t         cmd_r;
  logic [VW-1:0]    val_r;
  logic             in_range_r;
  logic             fok_r;
  logic [CW-1:0]    vc_rd_r;
  logic [PW-1:0]    pop_a_r, pop_b_r;
  logic [CW-1:0]    c_r, n_r;
  logic             from_ok_r, to_ok_r;
  logic             res_found_r;
  status_t          res_status_r;
  logic             out_valid_r;
  logic             found_r;
  status_t          status_r;

  logic          is_add, is_del, is_qry;
  logic          add_err, del_err, modify;
  logic [CW-1:0] n_nxt;
  status_t       status_nxt;
  logic          found_nxt;

  logic          vc_we;
  logic [VW-1:0] vc_wa;
  logic [CW-1:0] vc_wd;
  logic          pop_we;
  logic [CW-1:0] pop_wa;
  logic [PW-1:0] pop_wd;
  logic [CW-1:0] pop_ra;

  always_comb begin
    is_add  = (cmd_r == CMD_ADD);
    is_del  = (cmd_r == CMD_DELETE);
    is_qry  = (cmd_r == CMD_QUERY);
    add_err = !in_range_r || (vc_rd_r >= CW'(MAX_COUNT));
    del_err = !in_range_r || (vc_rd_r == '0);
    modify  = (is_add && !add_err) || (is_del && !del_err);
    n_nxt   = is_add ? (vc_rd_r + CW'(1)) : (vc_rd_r - CW'(1));
    if (is_add && add_err) begin
      status_nxt = ST_SATURATED;
    end else if (is_del && del_err) begin
      status_nxt = ST_ABSENT;
    end else begin
      status_nxt = ST_OK;
    end
    found_nxt = is_qry && fok_r && (pop_a_r != '0);
  end

  assign sts.modify   = modify;
  assign sts.clr_last = (clr_r == CLR_W'(CLR_DEPTH - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r      <= in_command;
      val_r      <= VW'(in_value);
      in_range_r <= (32'(in_value) < 32'(NUM_VALUES));
      fok_r      <= (in_frequency != '0) && (32'(in_frequency) <= 32'(MAX_COUNT));
    end
    if (cmd.eval) begin
      c_r          <= vc_rd_r;
      n_r          <= n_nxt;
      from_ok_r    <= (vc_rd_r != '0);
      to_ok_r      <= (n_nxt != '0);
      res_found_r  <= found_nxt;
      res_status_r <= status_nxt;
    end
  end

  // count table: one write, one registered read
  always_comb begin
    vc_we = (cmd.clr && (32'(clr_r) < 32'(NUM_VALUES))) || cmd.upd;
    vc_wa = cmd.clr ? clr_r[VW-1:0] : val_r;
    vc_wd = cmd.clr ? '0 : n_nxt;
  end

  always_ff @(posedge clk) begin
    if (vc_we) vc_mem[vc_wa] <= vc_wd;
    if (cmd.capture) vc_rd_r <= vc_mem[VW'(in_value)];
  end

  // population table: one write, two registered reads
  always_comb begin
    pop_we = 1'b0;
    pop_wa = '0;
    pop_wd = '0;
    if (cmd.clr) begin
      pop_we = (32'(clr_r) < 32'(POP_DEPTH));
      pop_wa = clr_r[CW-1:0];
    end else if (cmd.wr_from) begin
      pop_we = from_ok_r && (pop_a_r != '0);
      pop_wa = c_r;
      pop_wd = pop_a_r - PW'(1);
    end else if (cmd.wr_to) begin
      pop_we = to_ok_r;
      pop_wa = n_r;
      pop_wd = pop_b_r + PW'(1);
    end
    pop_ra = cmd.capture ? CW'(in_frequency) : vc_rd_r;
  end

  always_ff @(posedge clk) begin
    if (pop_we) pop_mem[pop_wa] <= pop_wd;
    if (cmd.capture || cmd.upd) pop_a_r <= pop_mem[pop_ra];
    if (cmd.upd) pop_b_r <= pop_mem[n_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found_r  <= res_found_r;
      status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = found_r;
  assign out_status = status_r;

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && found_r) |-> (status_r == ST_OK))
    else $error("found word with non-ok status");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_to && to_ok_r) |-> (32'(pop_b_r) < 32'(NUM_VALUES)))
    else $error("population overflow");

endmodule

[hdl/frequency_of_counts_tracker_unit.sv]
`timescale 1ns / 1ps
// Frequency-of-counts tracker.
// in_word: valid/ready channel carrying command, value, frequency. A word is
//   taken when valid and ready are both high. Add raises a value's count,
//   delete lowers it, query asks whether any value holds exactly frequency.
// out_word: valid/ready channel, one word (found, status) per input word,
//   in input order.
// From accept to out_word.valid: query and rejected add/delete pass S_RDCNT
//   and S_RESP; an updating add/delete passes S_RDCNT, S_WRFROM, S_WRTO, S_RESP.
// Words do not overlap: in_word.ready is high only in S_IDLE. The pace is set
//   by the registered count-table read and the single population write port,
//   which takes the old-count and new-count updates in S_WRFROM and S_WRTO.
// Reset: both tables are cleared by a sweep of max(NUM_VALUES, MAX_COUNT + 1)
//   addresses (4096 at the defaults); in_word.ready stays low until it ends.
// Stall: the result sits in an output register; the next word is accepted
//   and worked on while it waits, and only the final load waits for
//   out_word.ready.

module frequency_of_counts_tracker_unit #(
  parameter int NUM_VALUES = 4096,
  parameter int MAX_COUNT  = 4095
) (
  input logic       clk,
  input logic       rst_n,
  ftc_in_if.sink    in_word,
  ftc_out_if.source out_word
);
  import ftc_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  assign in_word.ready = in_ready;

  ftc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftc_dp #(
    .NUM_VALUES (NUM_VALUES),
    .MAX_COUNT  (MAX_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_command   (in_word.command),
    .in_value     (in_word.value),
    .in_frequency (in_word.frequency),
    .out_valid    (out_word.valid),
    .out_ready    (out_word.ready),
    .out_found    (out_word.found),
    .out_status   (out_word.status)
  );

endmodule
